@@ design/dltq_pkg.sv @@
package dltq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int ID_W = $clog2(NUM_TIMERS);
  localparam int LINK_W = ID_W + 1;
  localparam int CNT_W = LINK_W;
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_TIMERS);

  typedef enum logic [1:0] {
    FUNC_ONESHOT  = 2'd0,
    FUNC_PERIODIC = 2'd1,
    FUNC_CANCEL   = 2'd2,
    FUNC_TICK     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DORMANT = 2'd0,
    ST_PENDING = 2'd1,
    ST_ACTIVE  = 2'd2
  } slot_st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CCHK,
    S_CSUCC,
    S_CADD,
    S_UWALK,
    S_CEND,
    S_EMIT1,
    S_TPSTART,
    S_TPNEXT,
    S_IWALK,
    S_IFIN,
    S_TDEC,
    S_TPOP,
    S_RNEXT,
    S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CCHK,
    OP_CSUCC,
    OP_CADD,
    OP_UWALK,
    OP_CEND,
    OP_EMIT1,
    OP_TPSTART,
    OP_TPNEXT,
    OP_IWALK,
    OP_IFIN,
    OP_TDEC,
    OP_TPOP,
    OP_RNEXT,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    func_t    func;
    logic     id_ok;
    slot_st_t st_id;
    logic     cur_none;
    logic     cur_match;
    logic     d_gt;
    logic     p_none;
    logic     head_none;
    logic     head_zero;
    logic     idx_zero;
    logic     idx_one;
    logic     cnt_zero;
    logic     period_nz;
  } stat_t;

endpackage

@@ design/delta_list_timer_queue.sv @@
// Delta-list timer queue for NUM_TIMERS slots. Raise start with func, timer_id
// and ticks while busy is low; the request is taken at that edge. Every request
// produces one or more results, each shown for exactly one cycle with done high;
// the receiver cannot stall them, and last marks the final one. A start or cancel
// checks the slot's state; a listed slot is first unlinked by a search of its
// list, an active one passing its delta on to its successor, and then the slot is
// re-armed as pending or made dormant. A tick walks the pending set and the sorted
// list one node per cycle to insert each pending timer, then decrements the head,
// pops expired timers and reloads periodic ones; each expiry gives one result.
module delta_list_timer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  func,
  input  logic [3:0]  timer_id,
  input  logic [31:0] ticks,
  output logic        busy,
  output logic        done,
  output logic        expired_valid,
  output logic [3:0]  expired_id,
  output logic        last,
  output logic        tick_needed
);
  import dltq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dltq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dltq_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .func          (func),
    .timer_id      (timer_id),
    .ticks         (ticks),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .expired_valid (expired_valid),
    .expired_id    (expired_id),
    .last          (last),
    .tick_needed   (tick_needed)
  );

endmodule

@@ design/dltq_ctrl.sv @@
module dltq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  dltq_pkg::stat_t stat,
  output dltq_pkg::cmd_t  cmd,
  output logic           busy
);
  import dltq_pkg::*;

  state_t state, state_next;
  logic   reins, reins_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reins <= 1'b0;
    end else begin
      state <= state_next;
      reins <= reins_next;
    end
  end

  always_comb begin
    state_next = state;
    reins_next = reins;
    cmd.op = OP_IDLE;
    case (state)
      S_IDLE: begin
        cmd.op = OP_IDLE;
        if (start) begin
          if (stat.func == FUNC_TICK) state_next = S_TPSTART;
          else if (stat.id_ok) state_next = S_CCHK;
          else state_next = S_EMIT1;
        end
      end
      S_CCHK: begin
        cmd.op = OP_CCHK;
        if (stat.st_id == ST_ACTIVE) state_next = S_CSUCC;
        else if (stat.st_id == ST_PENDING) state_next = S_UWALK;
        else state_next = S_CEND;
      end
      S_CSUCC: begin
        cmd.op = OP_CSUCC;
        state_next = S_CADD;
      end
      S_CADD: begin
        cmd.op = OP_CADD;
        state_next = S_UWALK;
      end
      S_UWALK: begin
        cmd.op = OP_UWALK;
        if (stat.cur_none || stat.cur_match) state_next = S_CEND;
      end
      S_CEND: begin
        cmd.op = OP_CEND;
        state_next = S_EMIT1;
      end
      S_EMIT1: begin
        cmd.op = OP_EMIT1;
        state_next = S_IDLE;
      end
      S_TPSTART: begin
        cmd.op = OP_TPSTART;
        state_next = S_TPNEXT;
      end
      S_TPNEXT: begin
        cmd.op = OP_TPNEXT;
        reins_next = 1'b0;
        if (stat.p_none) state_next = S_TDEC;
        else state_next = S_IWALK;
      end
      S_IWALK: begin
        cmd.op = OP_IWALK;
        if (stat.cur_none || stat.d_gt) state_next = S_IFIN;
      end
      S_IFIN: begin
        cmd.op = OP_IFIN;
        state_next = reins ? S_RNEXT : S_TPNEXT;
      end
      S_TDEC: begin
        cmd.op = OP_TDEC;
        state_next = stat.head_none ? S_EMIT1 : S_TPOP;
      end
      S_TPOP: begin
        cmd.op = OP_TPOP;
        if (stat.head_none || !stat.head_zero) state_next = S_RNEXT;
      end
      S_RNEXT: begin
        cmd.op = OP_RNEXT;
        if (stat.idx_zero) begin
          state_next = stat.cnt_zero ? S_EMIT1 : S_EMIT;
        end else if (stat.period_nz) begin
          reins_next = 1'b1;
          state_next = S_IWALK;
        end
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        if (stat.idx_one) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ design/dltq_dpath.sv @@
module dltq_dpath (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      func,
  input  logic [3:0]      timer_id,
  input  logic [31:0]     ticks,
  input  dltq_pkg::cmd_t  cmd,
  output dltq_pkg::stat_t stat,
  output logic            done,
  output logic            expired_valid,
  output logic [3:0]      expired_id,
  output logic            last,
  output logic            tick_needed
);
  import dltq_pkg::*;

  logic [31:0]       delta_ticks [NUM_TIMERS];
  logic [31:0]       period_ticks [NUM_TIMERS];
  logic [LINK_W-1:0] next_link [NUM_TIMERS];
  slot_st_t          slot_status [NUM_TIMERS];
  logic [ID_W-1:0]   exp_buf [NUM_TIMERS];

  logic [LINK_W-1:0] active_head, pending_head;
  func_t             req_func;
  logic [ID_W-1:0]   req_id;
  logic [31:0]       req_ticks;
  logic [LINK_W-1:0] cur, prev, succ, p;
  logic [31:0]       tmp;
  logic [ID_W-1:0]   ins_id;
  logic [31:0]       ins_val;
  logic              ul_pend;
  logic [CNT_W-1:0]  cnt, idx;

  logic [ID_W-1:0]   cur_a, head_a, p_a, succ_a, prev_a, rc;
  logic [31:0]       d_cur, t_fix;

  assign cur_a  = cur[ID_W-1:0];
  assign head_a = active_head[ID_W-1:0];
  assign p_a    = p[ID_W-1:0];
  assign succ_a = succ[ID_W-1:0];
  assign prev_a = prev[ID_W-1:0];
  assign rc     = exp_buf[ID_W'(idx - CNT_W'(1))];
  assign d_cur  = delta_ticks[cur_a];
  assign t_fix  = (req_ticks == 32'd0) ? 32'd1 : req_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_head <= LINK_NONE;
      pending_head <= LINK_NONE;
      for (int i = 0; i < NUM_TIMERS; i++) slot_status[i] <= ST_DORMANT;
    end else begin
      case (cmd.op)
        OP_IDLE: begin
          if (start) begin
            req_func <= func_t'(func);
            req_id <= ID_W'(timer_id);
            req_ticks <= ticks;
          end
        end
        OP_CCHK: begin
          cur <= pending_head;
          prev <= LINK_NONE;
          ul_pend <= 1'b1;
        end
        OP_CSUCC: begin
          tmp <= delta_ticks[req_id];
          succ <= next_link[req_id];
        end
        OP_CADD: begin
          if (succ != LINK_NONE) delta_ticks[succ_a] <= delta_ticks[succ_a] + tmp;
          cur <= active_head;
          prev <= LINK_NONE;
          ul_pend <= 1'b0;
        end
        OP_UWALK: begin
          if (cur != LINK_NONE) begin
            if (cur_a == req_id) begin
              if (prev == LINK_NONE) begin
                if (ul_pend) pending_head <= next_link[cur_a];
                else active_head <= next_link[cur_a];
              end else begin
                next_link[prev_a] <= next_link[cur_a];
              end
            end else begin
              prev <= cur;
              cur <= next_link[cur_a];
            end
          end
        end
        OP_CEND: begin
          if (req_func inside {FUNC_ONESHOT, FUNC_PERIODIC}) begin
            delta_ticks[req_id] <= t_fix;
            period_ticks[req_id] <= (req_func == FUNC_PERIODIC) ? t_fix : 32'd0;
            slot_status[req_id] <= ST_PENDING;
            next_link[req_id] <= pending_head;
            pending_head <= LINK_W'(req_id);
          end else begin
            slot_status[req_id] <= ST_DORMANT;
          end
        end
        OP_TPSTART: begin
          p <= pending_head;
          pending_head <= LINK_NONE;
          cnt <= '0;
        end
        OP_TPNEXT: begin
          if (p != LINK_NONE) begin
            ins_id <= p_a;
            ins_val <= delta_ticks[p_a];
            p <= next_link[p_a];
            cur <= active_head;
            prev <= LINK_NONE;
          end
        end
        OP_IWALK: begin
          if (cur != LINK_NONE) begin
            if (d_cur > ins_val) begin
              delta_ticks[cur_a] <= d_cur - ins_val;
            end else begin
              ins_val <= ins_val - d_cur;
              prev <= cur;
              cur <= next_link[cur_a];
            end
          end
        end
        OP_IFIN: begin
          delta_ticks[ins_id] <= ins_val;
          next_link[ins_id] <= cur;
          if (prev == LINK_NONE) active_head <= LINK_W'(ins_id);
          else next_link[prev_a] <= LINK_W'(ins_id);
          slot_status[ins_id] <= ST_ACTIVE;
        end
        OP_TDEC: begin
          if (active_head != LINK_NONE) delta_ticks[head_a] <= delta_ticks[head_a] - 32'd1;
        end
        OP_TPOP: begin
          if (active_head != LINK_NONE && delta_ticks[head_a] == 32'd0) begin
            exp_buf[cnt[ID_W-1:0]] <= head_a;
            cnt <= cnt + CNT_W'(1);
            active_head <= next_link[head_a];
          end else begin
            idx <= cnt;
          end
        end
        OP_RNEXT: begin
          if (idx == '0) begin
            idx <= cnt;
          end else begin
            idx <= idx - CNT_W'(1);
            if (period_ticks[rc] != 32'd0) begin
              ins_id <= rc;
              ins_val <= period_ticks[rc];
              cur <= active_head;
              prev <= LINK_NONE;
            end else begin
              slot_status[rc] <= ST_DORMANT;
            end
          end
        end
        OP_EMIT: begin
          idx <= idx - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.func      = (cmd.op == OP_IDLE) ? func_t'(func) : req_func;
    stat.id_ok     = (32'(timer_id) < NUM_TIMERS);
    stat.st_id     = slot_status[req_id];
    stat.cur_none  = (cur == LINK_NONE);
    stat.cur_match = (cur_a == req_id);
    stat.d_gt      = (d_cur > ins_val);
    stat.p_none    = (p == LINK_NONE);
    stat.head_none = (active_head == LINK_NONE);
    stat.head_zero = (delta_ticks[head_a] == 32'd0);
    stat.idx_zero  = (idx == '0);
    stat.idx_one   = (idx == CNT_W'(1));
    stat.cnt_zero  = (cnt == '0);
    stat.period_nz = (period_ticks[rc] != 32'd0);
  end

  assign done          = (cmd.op == OP_EMIT1) || (cmd.op == OP_EMIT);
  assign expired_valid = (cmd.op == OP_EMIT);
  assign expired_id    = (cmd.op == OP_EMIT) ? 4'(rc) : 4'd0;
  assign last          = (cmd.op == OP_EMIT1) || (idx == CNT_W'(1));
  assign tick_needed   = (active_head != LINK_NONE) || (pending_head != LINK_NONE);

endmodule
